>>> rtl/midpoint_circle_rasterizer_macros.svh
// Assertion macros for the midpoint circle rasterizer.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH

// Same-cycle implication, off during reset.
`define MCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mcr_pkg.sv
// Package for the midpoint circle rasterizer: payload structs, kind codes
// and default widths. No dependencies.
package mcr_pkg;

    localparam int COORD_BITS_DEF  = 16;
    localparam int RADIUS_BITS_DEF = 12;

    // Kind of result set held for emission
    localparam logic [1:0] K_START = 2'd0;
    localparam logic [1:0] K_STEP  = 2'd1;
    localparam logic [1:0] K_MARK  = 2'd2;

    // Input actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic        [12:0] diameter;
        logic               fill_mode;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic        [12:0] span_len;
        logic               has_pixel;
        logic               circle_done;
        logic               last_of_item;
    } t_out_item;

endpackage

>>> rtl/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer top level: outline points or filled spans.
// Depends on mcr_pkg and midpoint_circle_rasterizer_macros.svh.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//
// An input transaction is decoded into a set of one to eight results that drains
// one per cycle into the output register while the output is not stalled; the
// next transaction is taken in the cycle the last result of the set moves out.
// Synchronous active-low reset idles the block. A stall on the output holds the
// output register and the held set, which stalls the input until its last result
// moves out.
`include "midpoint_circle_rasterizer_macros.svh"

module midpoint_circle_rasterizer #(
    parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mcr_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mcr_pkg::t_out_item o_out_data
);
    import mcr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int RW = RADIUS_BITS;
    localparam int DW = RADIUS_BITS + 4;               // decision width
    localparam int HW = (RW + 1 > 13) ? RW + 1 : 13;  // radius compare width
    localparam logic [HW-1:0] RMAX = HW'((1 << RW) - 1);

    // Circle state
    logic                 r_busy, n_busy;
    logic                 r_filling, n_filling;
    logic [CW-1:0]        r_ccol, n_ccol;
    logic [CW-1:0]        r_crow, n_crow;
    logic [RW-1:0]        r_run_x, n_run_x;
    logic [RW-1:0]        r_run_y, n_run_y;
    logic signed [DW-1:0] r_dec, n_dec;

    // Result set waiting to drain
    logic          r_pv;
    logic [1:0]    r_kind, n_kind;
    logic          r_pfill, n_pfill;
    logic [2:0]    r_idx;
    logic [2:0]    r_lastidx, n_lastidx;
    logic [CW-1:0] r_pcx, n_pcx;
    logic [CW-1:0] r_pcy, n_pcy;
    logic [RW-1:0] r_a, n_a;
    logic [RW-1:0] r_b, n_b;

    // Output register
    logic          r_ov;
    logic [CW-1:0] r_ox, n_ox;
    logic [CW-1:0] r_oy, n_oy;
    logic [12:0]   r_olen, n_olen;
    logic          r_ohas, r_odone, r_olast;

    logic w_out_take, w_emit, w_last, w_in_acc;

    assign w_out_take = !r_ov || !i_out_stall;
    assign w_emit     = r_pv && w_out_take;
    assign w_last     = (r_idx == r_lastidx);
    assign o_in_stall = r_pv && !(w_emit && w_last);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // ---------------- Decode of an input transaction ----------------
    logic [HW-1:0]        w_half;
    logic [RW-1:0]        w_r;
    logic [RW-1:0]        w_yi, w_xi;
    logic signed [DW-1:0] w_diff;

    assign w_half = HW'(i_in_data.diameter[12:1]);
    assign w_r    = (w_half > RMAX) ? RW'(RMAX) : RW'(w_half);
    assign w_yi   = r_run_y + RW'(1);
    assign w_xi   = (r_dec <= 0) ? r_run_x : r_run_x - RW'(1);
    assign w_diff = signed'(DW'(w_yi)) - signed'(DW'(w_xi));

    always_comb begin
        n_busy    = r_busy;
        n_filling = r_filling;
        n_ccol    = r_ccol;
        n_crow    = r_crow;
        n_run_x   = r_run_x;
        n_run_y   = r_run_y;
        n_dec     = r_dec;
        n_kind    = K_MARK;
        n_pfill   = 1'b0;
        n_lastidx = 3'd0;
        n_pcx     = r_ccol;
        n_pcy     = r_crow;
        n_a       = w_xi;
        n_b       = w_yi;
        if (i_in_data.action == ACT_START) begin
            n_ccol    = CW'(i_in_data.center_x);
            n_crow    = CW'(i_in_data.center_y);
            n_filling = i_in_data.fill_mode;
            n_busy    = 1'b1;
            n_run_x   = w_r;
            n_run_y   = '0;
            n_dec     = signed'(DW'(1)) - signed'(DW'(w_r));
            n_kind    = K_START;
            n_pfill   = i_in_data.fill_mode && (w_r != '0);
            n_lastidx = ((w_r == '0) || i_in_data.fill_mode) ? 3'd0 : 3'd3;
            n_pcx     = CW'(i_in_data.center_x);
            n_pcy     = CW'(i_in_data.center_y);
            n_a       = w_r;
            n_b       = '0;
        end else if (!r_busy || (r_run_x <= r_run_y)) begin
            n_busy = 1'b0;                      // idle or finished: marker only
        end else begin
            n_run_x = w_xi;
            n_run_y = w_yi;
            if (r_dec <= 0) begin
                n_dec = r_dec + signed'(DW'({w_yi, 1'b1}));
            end else begin
                n_dec = r_dec + (w_diff <<< 1) + signed'(DW'(1));
            end
            if (w_xi < w_yi) begin
                n_busy = 1'b0;
            end else begin
                n_kind  = K_STEP;
                n_pfill = r_filling;
                // diagonal points are emitted once
                if (r_filling) begin
                    n_lastidx = (w_xi != w_yi) ? 3'd3 : 3'd1;
                end else begin
                    n_lastidx = (w_xi != w_yi) ? 3'd7 : 3'd3;
                end
            end
        end
    end

    // ---------------- Result generation from the held set ----------------
    logic [CW-1:0] w_ac, w_bc;
    logic [12:0]   w_len_a, w_len_b;

    assign w_ac    = CW'(r_a);
    assign w_bc    = CW'(r_b);
    assign w_len_a = 13'({r_a, 1'b1});
    assign w_len_b = 13'({r_b, 1'b1});

    always_comb begin
        n_ox   = '0;
        n_oy   = '0;
        n_olen = 13'd1;
        unique case (r_kind)
            K_START: begin
                if (r_pfill) begin
                    n_ox   = r_pcx - w_ac;
                    n_oy   = r_pcy;
                    n_olen = w_len_a;
                end else begin
                    unique case (r_idx)
                        3'd0:    begin n_ox = r_pcx + w_ac; n_oy = r_pcy;        end
                        3'd1:    begin n_ox = r_pcx;        n_oy = r_pcy - w_ac; end
                        3'd2:    begin n_ox = r_pcx;        n_oy = r_pcy + w_ac; end
                        default: begin n_ox = r_pcx - w_ac; n_oy = r_pcy;        end
                    endcase
                end
            end
            K_STEP: begin
                if (r_pfill) begin
                    unique case (r_idx)
                        3'd0: begin
                            n_ox = r_pcx - w_ac; n_oy = r_pcy - w_bc; n_olen = w_len_a;
                        end
                        3'd1: begin
                            n_ox = r_pcx - w_ac; n_oy = r_pcy + w_bc; n_olen = w_len_a;
                        end
                        3'd2: begin
                            n_ox = r_pcx - w_bc; n_oy = r_pcy - w_ac; n_olen = w_len_b;
                        end
                        default: begin
                            n_ox = r_pcx - w_bc; n_oy = r_pcy + w_ac; n_olen = w_len_b;
                        end
                    endcase
                end else begin
                    unique case (r_idx)
                        3'd0: begin n_ox = r_pcx + w_ac; n_oy = r_pcy + w_bc; end
                        3'd1: begin n_ox = r_pcx - w_ac; n_oy = r_pcy + w_bc; end
                        3'd2: begin n_ox = r_pcx + w_ac; n_oy = r_pcy - w_bc; end
                        3'd3: begin n_ox = r_pcx - w_ac; n_oy = r_pcy - w_bc; end
                        3'd4: begin n_ox = r_pcx + w_bc; n_oy = r_pcy + w_ac; end
                        3'd5: begin n_ox = r_pcx - w_bc; n_oy = r_pcy + w_ac; end
                        3'd6: begin n_ox = r_pcx + w_bc; n_oy = r_pcy - w_ac; end
                        3'd7: begin n_ox = r_pcx - w_bc; n_oy = r_pcy - w_ac; end
                    endcase
                end
            end
            default: begin
                n_olen = '0;                    // marker
            end
        endcase
    end

    // ---------------- Registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_filling <= 1'b0;
            r_ccol    <= '0;
            r_crow    <= '0;
            r_run_x   <= '0;
            r_run_y   <= '0;
            r_dec     <= '0;
            r_pv      <= 1'b0;
            r_idx     <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy    <= n_busy;
                r_filling <= n_filling;
                r_ccol    <= n_ccol;
                r_crow    <= n_crow;
                r_run_x   <= n_run_x;
                r_run_y   <= n_run_y;
                r_dec     <= n_dec;
                r_pv      <= 1'b1;
                r_idx     <= '0;
            end else if (w_emit) begin
                if (w_last) begin
                    r_pv <= 1'b0;
                end
                r_idx <= r_idx + 3'd1;
            end
            if (w_out_take) begin
                r_ov <= w_emit;
            end
        end
    end

    // Payload of the held set and of the output register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_kind    <= n_kind;
            r_pfill   <= n_pfill;
            r_lastidx <= n_lastidx;
            r_pcx     <= n_pcx;
            r_pcy     <= n_pcy;
            r_a       <= n_a;
            r_b       <= n_b;
        end
        if (w_emit) begin
            r_ox    <= n_ox;
            r_oy    <= n_oy;
            r_olen  <= n_olen;
            r_ohas  <= (r_kind != K_MARK);
            r_odone <= (r_kind == K_MARK);
            r_olast <= w_last;
        end
    end

    assign o_out_valid              = r_ov;
    assign o_out_data.out_x         = 16'(r_ox);
    assign o_out_data.out_y         = 16'(r_oy);
    assign o_out_data.span_len      = r_olen;
    assign o_out_data.has_pixel     = r_ohas;
    assign o_out_data.circle_done   = r_odone;
    assign o_out_data.last_of_item  = r_olast;

    // ---------------- Assertions ----------------
    `MCR_ASSERT_NOW(a_idx_in_set, r_pv, r_idx <= r_lastidx, "index past end of result set")
    `MCR_ASSERT_NOW(a_mark_single, r_pv && (r_kind == K_MARK), r_lastidx == 3'd0, "long marker")
    `MCR_ASSERT_NOW(a_done_is_last, r_ov && r_odone, r_olast && !r_ohas, "bad marker")
    `MCR_ASSERT_NOW(a_run_order, r_busy, r_run_x >= r_run_y, "busy with octant past its end")
    `MCR_ASSERT_NEXT(a_emit_loads_out, w_emit, r_ov, "emitted result not held in output register")

endmodule

>>> test/midpoint_circle_rasterizer_test.sv
// Self-checking testbench for midpoint_circle_rasterizer: directed table, then random circles.
// Depends on mcr_pkg and the rasterizer RTL; predicts every result transaction in-line.
module midpoint_circle_rasterizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcr_pkg::*;

    localparam int          RANDOM_ITEMS = 125;
    localparam int          IDLE_PCT     = 27;
    localparam int          DRAIN_CYCLES = 24;       // a set is at most 8 results, plus margin
    localparam int          HOLD_CYCLES  = 400;      // long output hold-off to back up the input
    localparam int          HOLD_AT      = 120;      // result count that triggers the hold-off
    localparam int unsigned CYCLE_LIMIT  = 200000;

    // End-of-circle / idle marker: no pixel, done and last set.
    localparam t_out_item MARK = '{out_x: '0, out_y: '0, span_len: '0, has_pixel: 1'b0,
                                   circle_done: 1'b1, last_of_item: 1'b1};

    // One row of the directed table; want is only used when typed is set.
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_plan_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Circle state tracked by the predictor
    logic               circ_busy = 1'b0;
    logic               circ_fill = 1'b0;
    logic        [15:0] circ_cx   = '0;
    logic        [15:0] circ_cy   = '0;
    logic        [11:0] circ_x    = '0;
    logic        [11:0] circ_y    = '0;
    logic signed [15:0] circ_dec  = '0;

    t_out_item batch[$];            // results of the latest accepted input transaction
    t_out_item pending_pixels[$];   // expected results not yet seen on the output
    t_plan_row plan[$];

    int  fault_count = 0;
    int  items_sent  = 0;
    int  pixels_seen = 0;
    bit  calm        = 1'b0;        // set during the stretch with no idling on either side

    midpoint_circle_rasterizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_in_item cmd(input logic act, input int cx, input int cy,
                                     input int dia, input logic fill);
        t_in_item it;
        it.action    = act;
        it.center_x  = 16'(cx);
        it.center_y  = 16'(cy);
        it.diameter  = 13'(dia);
        it.fill_mode = fill;
        return it;
    endfunction

    function automatic t_out_item pixel(input logic [15:0] x, input logic [15:0] y,
                                        input logic [12:0] len, input logic last);
        t_out_item p;
        p.out_x        = x;
        p.out_y        = y;
        p.span_len     = len;
        p.has_pixel    = 1'b1;
        p.circle_done  = 1'b0;
        p.last_of_item = last;
        return p;
    endfunction

    function automatic void plot(input logic [15:0] x, input logic [15:0] y,
                                 input logic [12:0] len);
        batch.push_back(pixel(x, y, len, 1'b0));
    endfunction

    // Predictor: updates the circle state for one input transaction and
    // leaves the results it causes in batch. Coordinates wrap at 16 bits.
    function automatic void advance_circle(input t_in_item it);
        logic [11:0] r;
        logic [11:0] xi;
        logic [11:0] yi;
        int          d;
        batch = {};
        if (it.action == ACT_START) begin
            // radius is diameter >> 1, always within 12 bits so never saturates
            r         = it.diameter[12:1];
            circ_cx   = it.center_x;
            circ_cy   = it.center_y;
            circ_fill = it.fill_mode;
            circ_busy = 1'b1;
            circ_x    = r;
            circ_y    = '0;
            circ_dec  = 16'(1 - int'(r));
            if (r == 0) begin
                plot(circ_cx, circ_cy, 13'd1);
            end else if (circ_fill) begin
                plot(circ_cx - r, circ_cy, {r, 1'b1});
            end else begin
                plot(circ_cx + r, circ_cy, 13'd1);
                plot(circ_cx, circ_cy - r, 13'd1);
                plot(circ_cx, circ_cy + r, 13'd1);
                plot(circ_cx - r, circ_cy, 13'd1);
            end
        end else if (!circ_busy || circ_x <= circ_y) begin
            // idle, or the octant already ran out: marker only
            batch.push_back(MARK);
            circ_busy = 1'b0;
        end else begin
            yi = circ_y + 12'd1;
            xi = circ_x;
            d  = circ_dec;
            if (d <= 0) begin
                d += 2 * int'(yi) + 1;
            end else begin
                xi = xi - 12'd1;
                d += 2 * (int'(yi) - int'(xi)) + 1;
            end
            circ_x   = xi;
            circ_y   = yi;
            circ_dec = 16'(d);
            if (xi < yi) begin
                batch.push_back(MARK);
                circ_busy = 1'b0;
            end else if (circ_fill) begin
                plot(circ_cx - xi, circ_cy - yi, {xi, 1'b1});
                plot(circ_cx - xi, circ_cy + yi, {xi, 1'b1});
                // on the diagonal the mirrored spans would repeat
                if (xi != yi) begin
                    plot(circ_cx - yi, circ_cy - xi, {yi, 1'b1});
                    plot(circ_cx - yi, circ_cy + xi, {yi, 1'b1});
                end
            end else begin
                plot(circ_cx + xi, circ_cy + yi, 13'd1);
                plot(circ_cx - xi, circ_cy + yi, 13'd1);
                plot(circ_cx + xi, circ_cy - yi, 13'd1);
                plot(circ_cx - xi, circ_cy - yi, 13'd1);
                if (xi != yi) begin
                    plot(circ_cx + yi, circ_cy + xi, 13'd1);
                    plot(circ_cx - yi, circ_cy + xi, 13'd1);
                    plot(circ_cx + yi, circ_cy - xi, 13'd1);
                    plot(circ_cx - yi, circ_cy - xi, 13'd1);
                end
            end
        end
        batch[batch.size() - 1].last_of_item = 1'b1;
    endfunction

    task automatic flag_fault(input string msg);
        fault_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Offers one input transaction, with random idle cycles ahead of it,
    // and books its expected results once the block accepts it.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        advance_circle(it);
        if (typed) begin
            pending_pixels.push_back(want);
        end else begin
            foreach (batch[k]) pending_pixels.push_back(batch[k]);
        end
        items_sent++;
    endtask

    // Output side: checks each result transaction against the oldest
    // expectation and drives the output stall. One long hold-off is
    // counted here once HOLD_AT results have gone by, while the input side
    // keeps offering, so the block backs up and stalls its input.
    initial begin : result_side
        int        hold;
        t_out_item want;
        t_out_item got;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (pending_pixels.size() == 0) begin
                    flag_fault($sformatf("unexpected result %p", got));
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.out_x !== want.out_x)
                        flag_fault($sformatf("out_x %0d, want %0d", got.out_x, want.out_x));
                    if (got.out_y !== want.out_y)
                        flag_fault($sformatf("out_y %0d, want %0d", got.out_y, want.out_y));
                    if (got.span_len !== want.span_len)
                        flag_fault($sformatf("span_len %0d, want %0d",
                                             got.span_len, want.span_len));
                    if (got.has_pixel !== want.has_pixel)
                        flag_fault($sformatf("has_pixel %b, want %b",
                                             got.has_pixel, want.has_pixel));
                    if (got.circle_done !== want.circle_done)
                        flag_fault($sformatf("circle_done %b, want %b",
                                             got.circle_done, want.circle_done));
                    if (got.last_of_item !== want.last_of_item)
                        flag_fault($sformatf("last_of_item %b, want %b",
                                             got.last_of_item, want.last_of_item));
                end
                pixels_seen++;
                if (pixels_seen == HOLD_AT) hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Guards against a hung handshake.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("midpoint_circle_rasterizer_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_in_item it;
        int       cap;
        int       steps;
        int       total;

        // Directed table. Typed expectations only where obvious; the rest
        // go through the predictor.
        // step right after reset: block is idle, so only the marker
        plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b1, MARK});
        // zero radius: single centre point, then marker, then idle marker
        plan.push_back('{cmd(ACT_START, 0, 0, 0, 1'b0), 1'b1,
                         pixel(16'd0, 16'd0, 13'd1, 1'b1)});
        plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b1, MARK});
        plan.push_back('{cmd(ACT_STEP, -1, -1, 8191, 1'b1), 1'b1, MARK});
        // zero radius in fill mode at the coordinate extremes (diameter 1)
        plan.push_back('{cmd(ACT_START, 32767, -32768, 1, 1'b1), 1'b1,
                         pixel(16'sd32767, 16'h8000, 13'd1, 1'b1)});
        plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b1, MARK});
        // widest fill: radius 4095, full 8191-cell centre span
        plan.push_back('{cmd(ACT_START, 0, 0, 8191, 1'b1), 1'b1,
                         pixel(-16'sd4095, 16'd0, 13'd8191, 1'b1)});
        plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b0, MARK});
        plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b0, MARK});
        // widest outline at the opposite corner: coordinates wrap
        plan.push_back('{cmd(ACT_START, -32768, 32767, 8190, 1'b0), 1'b0, MARK});
        plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b0, MARK});
        // radius 5 outline run to completion
        plan.push_back('{cmd(ACT_START, 100, -100, 10, 1'b0), 1'b0, MARK});
        repeat (4) plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b0, MARK});
        // radius 3 fill: second step lands on the diagonal
        plan.push_back('{cmd(ACT_START, -5, 7, 7, 1'b1), 1'b0, MARK});
        repeat (3) plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b0, MARK});
        // radius 3 outline: diagonal step emits four points only
        plan.push_back('{cmd(ACT_START, 1, 1, 6, 1'b0), 1'b0, MARK});
        repeat (2) plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b0, MARK});
        // start while busy abandons the running circle
        plan.push_back('{cmd(ACT_START, -32768, -32768, 255, 1'b1), 1'b0, MARK});
        plan.push_back('{cmd(ACT_STEP, 0, 0, 0, 1'b0), 1'b0, MARK});
        total = plan.size() + RANDOM_ITEMS;

        // synchronous reset, once
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) send_item(plan[k].item, plan[k].typed, plan[k].want);

        // Random part: mostly whole circles (start then steps until done or
        // abandoned), with some stray transactions of any kind mixed in.
        while (items_sent < total) begin
            calm = (items_sent >= plan.size() + 40) && (items_sent < plan.size() + 80);
            if ($urandom_range(0, 99) < 15) begin
                send_item(cmd(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                              1'($urandom_range(0, 1))), 1'b0, MARK);
            end else begin
                it = cmd(ACT_START, $urandom, $urandom, $urandom_range(0, 48),
                         1'($urandom_range(0, 1)));
                // now and then a full-range diameter, cut short by the step cap
                if ($urandom_range(0, 9) == 0) it.diameter = 13'($urandom);
                send_item(it, 1'b0, MARK);
                cap   = $urandom_range(2, 40);
                steps = 0;
                // step fields other than action are don't-care: fill with noise
                while (circ_busy && steps < cap && items_sent < total) begin
                    send_item(cmd(ACT_STEP, $urandom, $urandom, $urandom,
                                  1'($urandom_range(0, 1))), 1'b0, MARK);
                    steps++;
                end
                // occasional extra step, on an idle block unless the step cap cut the circle short
                if ($urandom_range(0, 3) == 0 && items_sent < total)
                    send_item(cmd(ACT_STEP, $urandom, $urandom, $urandom,
                                  1'($urandom_range(0, 1))), 1'b0, MARK);
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && pending_pixels.size() == 0) begin
            $display("midpoint_circle_rasterizer_test: done, clean");
        end else begin
            $display("midpoint_circle_rasterizer_test: done, errors");
        end
        $finish;
    end

endmodule
